>>> rtl/s2c_pkg.sv
`timescale 1ns / 1ps
// s2c_pkg: shared types, widths and constants for the spherical-to-camera rotation block.
// No dependencies; imported by every module under rtl/.
package s2c_pkg;

  localparam int CORDIC_STEPS = 16;
  // More than 24 steps adds nothing: the arctangent table ends there.
  localparam int CORDIC_ITERS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

  localparam int FRAC   = 24;
  localparam int IN_W   = 16;
  localparam int OUT_W  = 16;
  localparam int THR_W  = 15;
  localparam int VAL_W  = 27;            // Q.24 vector element, signed
  localparam int ANG_W  = 28;            // Q.24 angle accumulator, signed
  localparam int PROD_W = 2 * VAL_W;     // full product of two elements
  localparam int DIFF_W = PROD_W + 1;    // difference of two products

  // normalizer
  localparam int MAG_W  = VAL_W;         // magnitude of one element
  localparam int SUM_W  = 2 * MAG_W;     // sum of three squares
  localparam int ROOT_W = SUM_W / 2;     // floor square root
  localparam int QUO_W  = FRAC + 1;      // quotient never exceeds 1.0
  localparam int NUM_W  = MAG_W + FRAC + 1;

  localparam logic signed [VAL_W-1:0]  CORDIC_GAIN = VAL_W'(10188014);
  localparam logic signed [ANG_W-1:0]  HALF_PI     = ANG_W'(26353589);
  localparam logic signed [ANG_W-1:0]  PI_Q24      = ANG_W'(52707179);
  localparam logic signed [VAL_W-1:0]  ONE_Q24     = VAL_W'(1) << FRAC;
  localparam logic signed [PROD_W-1:0] RND_Q24     = PROD_W'(1) << (FRAC - 1);

  localparam logic signed [ANG_W-1:0] ATAN_Q24 [24] = '{
    ANG_W'(13176795), ANG_W'(7778716), ANG_W'(4110060), ANG_W'(2086331),
    ANG_W'(1047214),  ANG_W'(524117),  ANG_W'(262123),  ANG_W'(131069),
    ANG_W'(65536),    ANG_W'(32768),   ANG_W'(16384),   ANG_W'(8192),
    ANG_W'(4096),     ANG_W'(2048),    ANG_W'(1024),    ANG_W'(512),
    ANG_W'(256),      ANG_W'(128),     ANG_W'(64),      ANG_W'(32),
    ANG_W'(16),       ANG_W'(8),       ANG_W'(4),       ANG_W'(2)
  };

  typedef logic signed [VAL_W-1:0] s2c_val_t;

  typedef struct packed {
    s2c_val_t x;
    s2c_val_t y;
    s2c_val_t z;
  } s2c_vec_t;

  // data that rides alongside a vector through the normalizer and cross units
  typedef struct packed {
    logic     near;
    s2c_val_t cp;
    s2c_val_t sp;
    s2c_vec_t rz;
    s2c_vec_t rx;
  } s2c_side_t;

endpackage

>>> rtl/spherical_to_camera_rotation.sv
`timescale 1ns / 1ps
// spherical_to_camera_rotation: top level; CORDIC, normalizers and cross units in one pipeline.
// Depends on s2c_pkg, s2c_cordic, s2c_norm, s2c_cross.
//
//  channel | handshake              | beat
//  --------+------------------------+---------------------------------------------
//  input   | start high, busy low   | polar_angle_i, azimuth_angle_i (Q3.13)
//  result  | done_o, one cycle      | row_x/y/z_0..2_o (Q1.14), near_pole_o
//  config  | APB, pready tied high  | pole_threshold at byte address 0
//
// A new beat is taken every cycle; busy stays low.
// The pipeline runs the CORDIC, then the normalizers and cross units; each of the
// three normalizers has 57 stages, set by the bit-per-stage square root and divide.
// Reset clears all valid bits and loads pole_threshold with 16220.
// The result side has no back-pressure, so nothing ever stalls.
module spherical_to_camera_rotation (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [s2c_pkg::IN_W-1:0]  polar_angle_i,
  input  logic signed [s2c_pkg::IN_W-1:0]  azimuth_angle_i,
  output logic                             done_o,
  output logic signed [s2c_pkg::OUT_W-1:0] row_x_0_o,
  output logic signed [s2c_pkg::OUT_W-1:0] row_x_1_o,
  output logic signed [s2c_pkg::OUT_W-1:0] row_x_2_o,
  output logic signed [s2c_pkg::OUT_W-1:0] row_y_0_o,
  output logic signed [s2c_pkg::OUT_W-1:0] row_y_1_o,
  output logic signed [s2c_pkg::OUT_W-1:0] row_y_2_o,
  output logic signed [s2c_pkg::OUT_W-1:0] row_z_0_o,
  output logic signed [s2c_pkg::OUT_W-1:0] row_z_1_o,
  output logic signed [s2c_pkg::OUT_W-1:0] row_z_2_o,
  output logic                             near_pole_o
);
  import s2c_pkg::*;

  localparam logic REG_THRESHOLD = 1'b0;
  localparam int   OUT_SHIFT     = FRAC - 14;
  localparam logic signed [VAL_W-1:0] OUT_RND = VAL_W'(1) << (OUT_SHIFT - 1);
  localparam logic signed [VAL_W-1:0] OUT_MAX = VAL_W'(16384);

  function automatic logic [OUT_W-1:0] to_out(s2c_val_t v);
    logic signed [VAL_W-1:0] q;
    q = (v + OUT_RND) >>> OUT_SHIFT;
    if (q > OUT_MAX) begin
      q = OUT_MAX;
    end else if (q < -OUT_MAX) begin
      q = -OUT_MAX;
    end
    return q[OUT_W-1:0];
  endfunction

  // ---------------- configuration ----------------
  logic [THR_W-1:0] thr_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_W'(16220);
    end else if (cfg_wr && (paddr[2] == REG_THRESHOLD)) begin
      thr_q <= pwdata[THR_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_THRESHOLD) ? 32'(thr_q) : '0;

  // ---------------- sine and cosine ----------------
  logic     in_acc;
  logic     cv_t, cv_p;
  s2c_val_t st, ct, sp, cp;

  assign busy   = 1'b0;
  assign in_acc = start && !busy;

  s2c_cordic u_cordic_t (
    .clk_i, .rst_ni, .valid_i(in_acc), .angle_i(polar_angle_i),
    .valid_o(cv_t), .sin_o(st), .cos_o(ct)
  );

  s2c_cordic u_cordic_p (
    .clk_i, .rst_ni, .valid_i(in_acc), .angle_i(azimuth_angle_i),
    .valid_o(cv_p), .sin_o(sp), .cos_o(cp)
  );

  // ---------------- raw view direction ----------------
  logic                     mv1_q, mv2_q;
  logic signed [PROD_W-1:0] p_cp_q, p_sp_q;
  s2c_val_t                 ct1_q, cp1_q, sp1_q;
  s2c_vec_t                 raw_q;
  s2c_side_t                raw_side_q, raw_side_d;
  logic signed [PROD_W-1:0] r_cp, r_sp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv1_q <= 1'b0;
      mv2_q <= 1'b0;
    end else begin
      mv1_q <= cv_t && cv_p;
      mv2_q <= mv1_q;
    end
  end

  assign r_cp = p_cp_q + RND_Q24;
  assign r_sp = p_sp_q + RND_Q24;

  always_comb begin
    raw_side_d    = '0;
    raw_side_d.cp = cp1_q;
    raw_side_d.sp = sp1_q;
  end

  always_ff @(posedge clk_i) begin
    p_cp_q <= st * cp;
    p_sp_q <= st * sp;
    ct1_q  <= ct;
    cp1_q  <= cp;
    sp1_q  <= sp;
    raw_q.x         <= VAL_W'(r_cp >>> FRAC);
    raw_q.y         <= VAL_W'(r_sp >>> FRAC);
    raw_q.z         <= ct1_q;
    raw_side_q      <= raw_side_d;
  end

  // ---------------- z row ----------------
  logic      na_v;
  s2c_vec_t  rz;
  s2c_side_t na_side;

  s2c_norm u_norm_z (
    .clk_i, .rst_ni, .valid_i(mv2_q), .vec_i(raw_q), .side_i(raw_side_q),
    .valid_o(na_v), .vec_o(rz), .side_o(na_side)
  );

  // ---------------- pole test and up vector ----------------
  logic             up_v_q;
  s2c_vec_t         up_q;
  s2c_side_t        up_side_q, up_side_d;
  logic [MAG_W-1:0] dot_mag;
  logic             near;

  assign dot_mag = rz.z[VAL_W-1] ? MAG_W'(-rz.z) : MAG_W'(rz.z);
  assign near    = dot_mag >= (MAG_W'(thr_q) << OUT_SHIFT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_v_q <= 1'b0;
    end else begin
      up_v_q <= na_v;
    end
  end

  always_comb begin
    up_side_d      = na_side;
    up_side_d.rz   = rz;
    up_side_d.near = near;
  end

  always_ff @(posedge clk_i) begin
    up_side_q <= up_side_d;
    if (near) begin
      up_q.x <= na_side.cp;
      up_q.y <= na_side.sp;
      up_q.z <= '0;
    end else begin
      up_q.x <= '0;
      up_q.y <= '0;
      up_q.z <= -ONE_Q24;
    end
  end

  // ---------------- x row ----------------
  logic      xa_v, xn_v;
  s2c_vec_t  xa_vec, rx;
  s2c_side_t xa_side, xn_side, yb_side_in;

  s2c_cross u_cross_x (
    .clk_i, .rst_ni, .valid_i(up_v_q), .a_i(up_q), .b_i(up_side_q.rz),
    .side_i(up_side_q), .valid_o(xa_v), .vec_o(xa_vec), .side_o(xa_side)
  );

  s2c_norm u_norm_x (
    .clk_i, .rst_ni, .valid_i(xa_v), .vec_i(xa_vec), .side_i(xa_side),
    .valid_o(xn_v), .vec_o(rx), .side_o(xn_side)
  );

  // ---------------- y row ----------------
  logic      ya_v, yn_v;
  s2c_vec_t  ya_vec, ry;
  s2c_side_t ya_side, yn_side;

  always_comb begin
    yb_side_in    = xn_side;
    yb_side_in.rx = rx;
  end

  s2c_cross u_cross_y (
    .clk_i, .rst_ni, .valid_i(xn_v), .a_i(xn_side.rz), .b_i(rx),
    .side_i(yb_side_in), .valid_o(ya_v), .vec_o(ya_vec), .side_o(ya_side)
  );

  s2c_norm u_norm_y (
    .clk_i, .rst_ni, .valid_i(ya_v), .vec_i(ya_vec), .side_i(ya_side),
    .valid_o(yn_v), .vec_o(ry), .side_o(yn_side)
  );

  // ---------------- output register ----------------
  logic             done_q, near_q;
  logic [OUT_W-1:0] rx0_q, rx1_q, rx2_q, ry0_q, ry1_q, ry2_q, rz0_q, rz1_q, rz2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= yn_v;
    end
  end

  always_ff @(posedge clk_i) begin
    rx0_q  <= to_out(yn_side.rx.x);
    rx1_q  <= to_out(yn_side.rx.y);
    rx2_q  <= to_out(yn_side.rx.z);
    ry0_q  <= to_out(ry.x);
    ry1_q  <= to_out(ry.y);
    ry2_q  <= to_out(ry.z);
    rz0_q  <= to_out(yn_side.rz.x);
    rz1_q  <= to_out(yn_side.rz.y);
    rz2_q  <= to_out(yn_side.rz.z);
    near_q <= yn_side.near;
  end

  assign done_o      = done_q;
  assign row_x_0_o   = rx0_q;
  assign row_x_1_o   = rx1_q;
  assign row_x_2_o   = rx2_q;
  assign row_y_0_o   = ry0_q;
  assign row_y_1_o   = ry1_q;
  assign row_y_2_o   = ry2_q;
  assign row_z_0_o   = rz0_q;
  assign row_z_1_o   = rz1_q;
  assign row_z_2_o   = rz2_q;
  assign near_pole_o = near_q;

endmodule

>>> rtl/s2c_cordic.sv
`timescale 1ns / 1ps
// s2c_cordic: pipelined rotation-mode CORDIC, one iteration per stage, sine and cosine in Q.24.
// Depends on s2c_pkg.
module s2c_cordic (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic signed [s2c_pkg::IN_W-1:0] angle_i,
  output logic                           valid_o,
  output s2c_pkg::s2c_val_t              sin_o,
  output s2c_pkg::s2c_val_t              cos_o
);
  import s2c_pkg::*;

  logic                    vld_q [CORDIC_ITERS+1];
  logic                    neg_q [CORDIC_ITERS+1];
  logic signed [ANG_W-1:0] a_q   [CORDIC_ITERS+1];
  s2c_val_t                x_q   [CORDIC_ITERS+1];
  s2c_val_t                y_q   [CORDIC_ITERS+1];

  logic signed [ANG_W-1:0] a_in;
  logic                    valid_q;
  s2c_val_t                sin_q, cos_q;

  // Q3.13 to Q.24, then fold into [-pi/2, pi/2]
  assign a_in = ANG_W'($signed({angle_i, 11'b0}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0] <= CORDIC_GAIN;
    y_q[0] <= '0;
    if (a_in > HALF_PI) begin
      a_q[0]   <= a_in - PI_Q24;
      neg_q[0] <= 1'b1;
    end else if (a_in < -HALF_PI) begin
      a_q[0]   <= a_in + PI_Q24;
      neg_q[0] <= 1'b1;
    end else begin
      a_q[0]   <= a_in;
      neg_q[0] <= 1'b0;
    end
  end

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      neg_q[i+1] <= neg_q[i];
      if (!a_q[i][ANG_W-1]) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        a_q[i+1] <= a_q[i] - ATAN_Q24[i];
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        a_q[i+1] <= a_q[i] + ATAN_Q24[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= vld_q[CORDIC_ITERS];
    end
  end

  always_ff @(posedge clk_i) begin
    cos_q <= neg_q[CORDIC_ITERS] ? -x_q[CORDIC_ITERS] : x_q[CORDIC_ITERS];
    sin_q <= neg_q[CORDIC_ITERS] ? -y_q[CORDIC_ITERS] : y_q[CORDIC_ITERS];
  end

  assign valid_o = valid_q;
  assign sin_o   = sin_q;
  assign cos_o   = cos_q;

endmodule

>>> rtl/s2c_cross.sv
`timescale 1ns / 1ps
// s2c_cross: two-stage cross product a x b of Q.24 vectors, rounded back to Q.24.
// Depends on s2c_pkg.
module s2c_cross (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  s2c_pkg::s2c_vec_t  a_i,
  input  s2c_pkg::s2c_vec_t  b_i,
  input  s2c_pkg::s2c_side_t side_i,
  output logic               valid_o,
  output s2c_pkg::s2c_vec_t  vec_o,
  output s2c_pkg::s2c_side_t side_o
);
  import s2c_pkg::*;

  logic                     vld1_q, vld2_q;
  logic signed [PROD_W-1:0] p_q [6];
  s2c_side_t                side1_q, side2_q;
  s2c_vec_t                 vec_q;
  logic signed [DIFF_W-1:0] dx, dy, dz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q[0]  <= $signed(a_i.y) * $signed(b_i.z);
    p_q[1]  <= $signed(a_i.z) * $signed(b_i.y);
    p_q[2]  <= $signed(a_i.z) * $signed(b_i.x);
    p_q[3]  <= $signed(a_i.x) * $signed(b_i.z);
    p_q[4]  <= $signed(a_i.x) * $signed(b_i.y);
    p_q[5]  <= $signed(a_i.y) * $signed(b_i.x);
    side1_q <= side_i;
  end

  assign dx = DIFF_W'(p_q[0]) - DIFF_W'(p_q[1]) + DIFF_W'(RND_Q24);
  assign dy = DIFF_W'(p_q[2]) - DIFF_W'(p_q[3]) + DIFF_W'(RND_Q24);
  assign dz = DIFF_W'(p_q[4]) - DIFF_W'(p_q[5]) + DIFF_W'(RND_Q24);

  always_ff @(posedge clk_i) begin
    vec_q.x <= VAL_W'(dx >>> FRAC);
    vec_q.y <= VAL_W'(dy >>> FRAC);
    vec_q.z <= VAL_W'(dz >>> FRAC);
    side2_q <= side1_q;
  end

  assign valid_o = vld2_q;
  assign vec_o   = vec_q;
  assign side_o  = side2_q;

endmodule

>>> rtl/s2c_norm.sv
`timescale 1ns / 1ps
// s2c_norm: pipelined vector normalizer: squares, bit-per-stage square root,
// bit-per-stage restoring divide of each magnitude. Depends on s2c_pkg.
module s2c_norm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  s2c_pkg::s2c_vec_t  vec_i,
  input  s2c_pkg::s2c_side_t side_i,
  output logic               valid_o,
  output s2c_pkg::s2c_vec_t  vec_o,
  output s2c_pkg::s2c_side_t side_o
);
  import s2c_pkg::*;

  localparam int TRY_W = SUM_W + 2;

  typedef struct packed {
    logic [2:0]       neg;
    logic [MAG_W-1:0] m0;
    logic [MAG_W-1:0] m1;
    logic [MAG_W-1:0] m2;
    s2c_side_t        side;
  } carry_t;

  // magnitude and square stages
  logic             vld1_q, vld2_q;
  carry_t           c1_q, c2_q;
  logic [SUM_W-1:0] sq_q [3];

  // square root: index 0 holds the sum
  logic              sv_q    [ROOT_W+1];
  carry_t            sc_q    [ROOT_W+1];
  logic [SUM_W-1:0]  rem_q   [ROOT_W+1];
  logic [ROOT_W-1:0] root_q  [ROOT_W+1];

  // divide: index 0 holds the prepared numerators
  logic              dv_q    [QUO_W+1];
  logic [2:0]        dneg_q  [QUO_W+1];
  s2c_side_t         dside_q [QUO_W+1];
  logic              dzero_q [QUO_W+1];
  logic [ROOT_W-1:0] dden_q  [QUO_W+1];
  logic [NUM_W-1:0]  drem_q  [QUO_W+1][3];
  logic [QUO_W-1:0]  quo_q   [QUO_W+1][3];

  logic              fv_q;
  s2c_vec_t          fvec_q;
  s2c_side_t         fside_q;
  logic [ROOT_W-1:0] n_root;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      sv_q[0] <= 1'b0;
    end else begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
      sv_q[0] <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c1_q.neg  <= {vec_i.z[VAL_W-1], vec_i.y[VAL_W-1], vec_i.x[VAL_W-1]};
    c1_q.m0   <= vec_i.x[VAL_W-1] ? MAG_W'(-vec_i.x) : MAG_W'(vec_i.x);
    c1_q.m1   <= vec_i.y[VAL_W-1] ? MAG_W'(-vec_i.y) : MAG_W'(vec_i.y);
    c1_q.m2   <= vec_i.z[VAL_W-1] ? MAG_W'(-vec_i.z) : MAG_W'(vec_i.z);
    c1_q.side <= side_i;
    sq_q[0]   <= c1_q.m0 * c1_q.m0;
    sq_q[1]   <= c1_q.m1 * c1_q.m1;
    sq_q[2]   <= c1_q.m2 * c1_q.m2;
    c2_q      <= c1_q;
    rem_q[0]  <= sq_q[0] + sq_q[1] + sq_q[2];
    root_q[0] <= '0;
    sc_q[0]   <= c2_q;
  end

  // one root bit per stage, most significant first
  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    localparam int B = ROOT_W - 1 - k;
    logic [TRY_W-1:0] trial;

    assign trial = (TRY_W'(root_q[k]) << (B + 1)) + (TRY_W'(1) << (2 * B));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k+1] <= 1'b0;
      end else begin
        sv_q[k+1] <= sv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      sc_q[k+1] <= sc_q[k];
      if (TRY_W'(rem_q[k]) >= trial) begin
        rem_q[k+1]  <= rem_q[k] - trial[SUM_W-1:0];
        root_q[k+1] <= root_q[k] | (ROOT_W'(1) << B);
      end else begin
        rem_q[k+1]  <= rem_q[k];
        root_q[k+1] <= root_q[k];
      end
    end
  end

  assign n_root = root_q[ROOT_W];

  // numerator = (mag << FRAC) + n/2, for round-to-nearest
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else begin
      dv_q[0] <= sv_q[ROOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    dneg_q[0]    <= sc_q[ROOT_W].neg;
    dside_q[0]   <= sc_q[ROOT_W].side;
    dzero_q[0]   <= (n_root == '0);
    dden_q[0]    <= n_root;
    drem_q[0][0] <= (NUM_W'(sc_q[ROOT_W].m0) << FRAC) + NUM_W'(n_root >> 1);
    drem_q[0][1] <= (NUM_W'(sc_q[ROOT_W].m1) << FRAC) + NUM_W'(n_root >> 1);
    drem_q[0][2] <= (NUM_W'(sc_q[ROOT_W].m2) << FRAC) + NUM_W'(n_root >> 1);
    quo_q[0][0]  <= '0;
    quo_q[0][1]  <= '0;
    quo_q[0][2]  <= '0;
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    localparam int J = QUO_W - 1 - k;
    logic [NUM_W-1:0] dsh;

    assign dsh = NUM_W'(dden_q[k]) << J;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else begin
        dv_q[k+1] <= dv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      dneg_q[k+1]  <= dneg_q[k];
      dside_q[k+1] <= dside_q[k];
      dzero_q[k+1] <= dzero_q[k];
      dden_q[k+1]  <= dden_q[k];
      for (int l = 0; l < 3; l++) begin
        if (drem_q[k][l] >= dsh) begin
          drem_q[k+1][l] <= drem_q[k][l] - dsh;
          quo_q[k+1][l]  <= quo_q[k][l] | (QUO_W'(1) << J);
        end else begin
          drem_q[k+1][l] <= drem_q[k][l];
          quo_q[k+1][l]  <= quo_q[k][l];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= dv_q[QUO_W];
    end
  end

  // zero-length vector gives an all-zero row
  always_ff @(posedge clk_i) begin
    fside_q <= dside_q[QUO_W];
    if (dzero_q[QUO_W]) begin
      fvec_q <= '0;
    end else begin
      fvec_q.x <= dneg_q[QUO_W][0] ? -VAL_W'(quo_q[QUO_W][0]) : VAL_W'(quo_q[QUO_W][0]);
      fvec_q.y <= dneg_q[QUO_W][1] ? -VAL_W'(quo_q[QUO_W][1]) : VAL_W'(quo_q[QUO_W][1]);
      fvec_q.z <= dneg_q[QUO_W][2] ? -VAL_W'(quo_q[QUO_W][2]) : VAL_W'(quo_q[QUO_W][2]);
    end
  end

  assign valid_o = fv_q;
  assign vec_o   = fvec_q;
  assign side_o  = fside_q;

endmodule

>>> rtl/s2c_checker.sv
`timescale 1ns / 1ps
// s2c_checker: port-level assertions for spherical_to_camera_rotation, bound to the top level.
// Depends on s2c_pkg and spherical_to_camera_rotation.
module s2c_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             done_o,
  input logic                             near_pole_o,
  input logic signed [s2c_pkg::OUT_W-1:0] row_x_2_o,
  input logic signed [s2c_pkg::OUT_W-1:0] row_z_0_o,
  input logic signed [s2c_pkg::OUT_W-1:0] row_z_2_o
);
  import s2c_pkg::*;

  localparam logic signed [OUT_W-1:0] LIM = OUT_W'(16384);

  // async reset must kill every strobe in flight
  a_quiet_in_reset: assert property (@(posedge clk_i) !rst_ni |=> !done_o)
    else $error("result strobe during reset");

  // default up vector lies along z only, so the x row lies in the xy plane
  a_x_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !near_pole_o |-> row_x_2_o == '0)
    else $error("x row has z part with default up vector");

  a_z_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> row_z_0_o <= LIM && row_z_0_o >= -LIM && row_z_2_o <= LIM && row_z_2_o >= -LIM)
    else $error("z row outside Q1.14 unit range");

  a_known_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !$isunknown({near_pole_o, row_x_2_o, row_z_0_o, row_z_2_o}))
    else $error("result beat carries unknown bits");

endmodule

bind spherical_to_camera_rotation s2c_checker u_s2c_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .done_o      (done_o),
  .near_pole_o (near_pole_o),
  .row_x_2_o   (row_x_2_o),
  .row_z_0_o   (row_z_0_o),
  .row_z_2_o   (row_z_2_o)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for spherical_to_camera_rotation; predicts each rotation
// in 64-bit integer arithmetic and compares every result beat. Depends on s2c_pkg and the RTL.
module tb_top;
  import s2c_pkg::*;

  localparam int LAT_WAIT = 240;

  typedef enum logic [1:0] {CMD_ANGLES, CMD_THRESH, CMD_DRAIN} cmd_kind_e;
  typedef enum logic [1:0] {DS_RUN, DS_SETUP, DS_ACCESS, DS_DRAIN} drv_state_e;
  localparam logic [2:0] ADDR_POLE_THR = 3'd0;

  typedef struct {
    cmd_kind_e   kind;
    logic [15:0] polar;
    logic [15:0] azim;
    logic [14:0] thr;
  } cmd_t;

  typedef struct packed {
    logic [8:0][15:0] rows;
    logic             near;
  } rot_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready, busy, done_o, near_pole_o;
  logic        start = 1'b0;
  logic signed [15:0] polar_angle_i = '0, azimuth_angle_i = '0;
  logic signed [15:0] rx0, rx1, rx2, ry0, ry1, ry2, rz0, rz1, rz2;

  cmd_t       cmd_q[$];
  rot_t       rot_expq[$];
  logic [14:0] thr_model = 15'd16220;
  drv_state_e drv_state = DS_RUN;
  logic       took = 1'b0;
  logic       all_sent = 1'b0;
  int         sent_cnt = 0;
  int         drain_cnt = 0;
  int         err_cnt = 0;

  spherical_to_camera_rotation u_top (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .polar_angle_i, .azimuth_angle_i, .done_o,
    .row_x_0_o(rx0), .row_x_1_o(rx1), .row_x_2_o(rx2),
    .row_y_0_o(ry0), .row_y_1_o(ry1), .row_y_2_o(ry2),
    .row_z_0_o(rz0), .row_z_1_o(rz1), .row_z_2_o(rz2),
    .near_pole_o
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------- predictor ----------------
  function automatic longint rnd_shr(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  task automatic sin_cos(input longint ang, output longint s, output longint c);
    logic   neg;
    longint x, y, nx;
    neg = 1'b0;
    x = 10188014;
    y = 0;
    if (ang > 26353589) begin
      ang = ang - 52707179; neg = 1'b1;
    end else if (ang < -26353589) begin
      ang = ang + 52707179; neg = 1'b1;
    end
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      if (ang >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        ang = ang - longint'(ATAN_Q24[i]);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        ang = ang + longint'(ATAN_Q24[i]);
      end
      x = nx;
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endtask

  task automatic unit_vec(input longint v[3], output longint r[3]);
    longint unsigned sum, n, mag;
    sum = 0;
    for (int k = 0; k < 3; k++) sum = sum + longint'(v[k] * v[k]);
    n = int_sqrt(sum);
    for (int k = 0; k < 3; k++) begin
      if (n == 0) begin
        r[k] = 0;
      end else begin
        mag = (v[k] < 0) ? -v[k] : v[k];
        mag = ((mag << 24) + n / 2) / n;
        r[k] = (v[k] < 0) ? -longint'(mag) : longint'(mag);
      end
    end
  endtask

  task automatic cross3(input longint a[3], input longint b[3], output longint r[3]);
    r[0] = rnd_shr(a[1] * b[2] - a[2] * b[1], 24);
    r[1] = rnd_shr(a[2] * b[0] - a[0] * b[2], 24);
    r[2] = rnd_shr(a[0] * b[1] - a[1] * b[0], 24);
  endtask

  function automatic logic [15:0] to_q14(longint v);
    longint q;
    q = rnd_shr(v, 10);
    if (q > 16384) q = 16384;
    if (q < -16384) q = -16384;
    return q[15:0];
  endfunction

  task automatic predict_rotation(input logic signed [15:0] th, input logic signed [15:0] ph,
                                  input logic [14:0] thr, output rot_t res);
    longint st, ct, sp, cp, mag_dot;
    longint raw[3], vz[3], up[3], t[3], vx[3], vy[3];
    logic   near;
    sin_cos(longint'(th) * 2048, st, ct);
    sin_cos(longint'(ph) * 2048, sp, cp);
    raw[0] = rnd_shr(st * cp, 24);
    raw[1] = rnd_shr(st * sp, 24);
    raw[2] = ct;
    unit_vec(raw, vz);
    mag_dot = (vz[2] < 0) ? -vz[2] : vz[2];
    near = !(mag_dot < (longint'(thr) << 10));
    if (near) begin
      up[0] = cp; up[1] = sp; up[2] = 0;
    end else begin
      up[0] = 0; up[1] = 0; up[2] = -(longint'(1) << 24);
    end
    cross3(up, vz, t);
    unit_vec(t, vx);
    cross3(vz, vx, t);
    unit_vec(t, vy);
    for (int k = 0; k < 3; k++) begin
      res.rows[k] = to_q14(vx[k]);
      res.rows[3 + k] = to_q14(vy[k]);
      res.rows[6 + k] = to_q14(vz[k]);
    end
    res.near = near;
  endtask

  // ---------------- checking ----------------
  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    err_cnt++;
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what,
             $signed(got), $signed(want));
  endtask

  always @(posedge clk_i) begin
    rot_t exp_r, got_r;
    static string fname[9] = '{"row_x_0", "row_x_1", "row_x_2", "row_y_0", "row_y_1",
                               "row_y_2", "row_z_0", "row_z_1", "row_z_2"};
    took <= rst_ni && start && !busy;
    if (rst_ni && start && !busy) begin
      predict_rotation(polar_angle_i, azimuth_angle_i, thr_model, exp_r);
      rot_expq.push_back(exp_r);
    end
    if (rst_ni && done_o) begin
      got_r.rows = {rz2, rz1, rz0, ry2, ry1, ry0, rx2, rx1, rx0};
      got_r.near = near_pole_o;
      if (rot_expq.size() == 0) begin
        report("unexpected beat", 16'd0, 16'd0);
      end else begin
        exp_r = rot_expq.pop_front();
        for (int k = 0; k < 9; k++)
          if (got_r.rows[k] !== exp_r.rows[k]) report(fname[k], got_r.rows[k], exp_r.rows[k]);
        if (got_r.near !== exp_r.near)
          report("near_pole", 16'(got_r.near), 16'(exp_r.near));
      end
    end
  end

  // ---------------- driver ----------------
  always @(negedge clk_i) begin
    cmd_t cmd;
    if (rst_ni) begin
      case (drv_state)
        DS_RUN: begin
          if (start && !took) begin
            // beat still waiting for acceptance
          end else if (cmd_q.size() == 0) begin
            start <= 1'b0;
            all_sent <= 1'b1;
          end else begin
            cmd = cmd_q[0];
            case (cmd.kind)
              CMD_ANGLES: begin
                if ((sent_cnt < 700 || sent_cnt >= 1000) && $urandom_range(99) < 21) begin
                  start <= 1'b0;
                end else begin
                  void'(cmd_q.pop_front());
                  sent_cnt <= sent_cnt + 1;
                  start <= 1'b1;
                  polar_angle_i <= cmd.polar;
                  azimuth_angle_i <= cmd.azim;
                end
              end
              CMD_THRESH: begin
                void'(cmd_q.pop_front());
                start <= 1'b0;
                psel <= 1'b1;
                penable <= 1'b0;
                pwrite <= 1'b1;
                paddr <= ADDR_POLE_THR;
                pwdata <= {17'd0, cmd.thr};
                thr_model <= cmd.thr;
                drv_state <= DS_SETUP;
              end
              default: begin
                void'(cmd_q.pop_front());
                start <= 1'b0;
                drain_cnt <= 0;
                drv_state <= DS_DRAIN;
              end
            endcase
          end
        end
        DS_SETUP: begin
          penable <= 1'b1;
          drv_state <= DS_ACCESS;
        end
        DS_ACCESS: begin
          psel <= 1'b0;
          penable <= 1'b0;
          pwrite <= 1'b0;
          drv_state <= DS_RUN;
        end
        default: begin
          if (rot_expq.size() != 0) drain_cnt <= 0;
          else if (drain_cnt >= LAT_WAIT) drv_state <= DS_RUN;
          else drain_cnt <= drain_cnt + 1;
        end
      endcase
    end
  end

  // ---------------- stimulus ----------------
  function automatic logic [15:0] rand_angle(bit polar);
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'($urandom);
    if (polar && r < 20) return 16'($urandom_range(0, 600) - 300);
    if (polar && r < 28) return 16'((r[0] ? 25736 : -25736) - $urandom_range(0, 300)
                                    + (r[0] ? 0 : 300));
    return 16'($urandom_range(0, 51472) - 25736);
  endfunction

  task automatic add_angles(input logic [15:0] th, input logic [15:0] ph);
    cmd_q.push_back('{CMD_ANGLES, th, ph, 15'd0});
  endtask

  task automatic add_thresh(input logic [14:0] thr);
    cmd_q.push_back('{CMD_DRAIN, 16'd0, 16'd0, 15'd0});
    cmd_q.push_back('{CMD_THRESH, 16'd0, 16'd0, thr});
  endtask

  initial begin
    static logic [15:0] edges[9] = '{16'h8000, 16'h7fff, 16'(-25736), 16'(25736), 16'd0,
                                     16'(12868), 16'(-12868), 16'hffff, 16'd1};
    static logic [14:0] thr_set[6] = '{15'd0, 15'h7fff, 15'd16384, 15'd16220, 15'd8192,
                                       15'd16383};
    // extremes, poles, equator
    for (int i = 0; i < 9; i++) add_angles(edges[i], edges[(i * 4 + 3) % 9]);
    for (int i = 0; i < 9; i++) add_angles(edges[(i + 2) % 9], edges[i]);
    for (int i = 0; i < 250; i++) add_angles(rand_angle(1), rand_angle(0));
    foreach (thr_set[p]) begin
      add_thresh(thr_set[p]);
      for (int i = 0; i < 4; i++) add_angles(edges[i + 3], edges[i]);
      for (int i = 0; i < 210; i++) add_angles(rand_angle(1), rand_angle(0));
    end
    add_thresh(15'($urandom_range(15000, 16384)));
    for (int i = 0; i < 40; i++) add_angles(rand_angle(1), rand_angle(0));
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (all_sent);
    wait (rot_expq.size() == 0);
    repeat (LAT_WAIT) @(posedge clk_i);
    if (err_cnt == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
